/* rtl/arpc_pkg.sv */
package arpc_pkg;

  // Table geometry
  localparam int unsigned CACHE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(CACHE_ENTRIES + 1);

  // Field widths
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SLOT_W = 4;

  // Request opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

endpackage

/* rtl/arpc_req_if.sv */
interface arpc_req_if;
  import arpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [IP_W-1:0]   ip_addr;
  logic [MAC_W-1:0]  mac_in;
  logic [TIME_W-1:0] now_ms;

  modport source (
    output valid, opcode, ip_addr, mac_in, now_ms,
    input  ready
  );

  modport sink (
    input  valid, opcode, ip_addr, mac_in, now_ms,
    output ready
  );

endinterface

/* rtl/arpc_rsp_if.sv */
interface arpc_rsp_if;
  import arpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [MAC_W-1:0]  mac_out;
  logic [SLOT_W-1:0] slot;

  modport source (
    output valid, found, mac_out, slot,
    input  ready
  );

  modport sink (
    input  valid, found, mac_out, slot,
    output ready
  );

endinterface

/* rtl/arp_cache_oldest_replace.sv */
// ARP cache of CACHE_ENTRIES IPv4-to-MAC entries with oldest-entry replacement.
// A request either looks up an address (returning its MAC on a hit) or adds
// an entry: a matching entry is refreshed, else the lowest free slot is
// filled, else the entry with the smallest timestamp is overwritten (lowest
// index on a tie; timestamps compare unsigned, without wrap handling). Every
// request yields exactly one response transaction. The block scans the entry
// memory one entry per cycle through a single address comparator and a single
// timestamp comparator. A request is taken in idle, every entry is read in
// turn, the last registered read is evaluated, then an add writes its entry
// and the response is registered once the previous response has been taken,
// and the block returns to idle to take the next request. The response is held
// in an output register, so a new request is taken while it waits. Reset clears
// every valid mark at once; no clearing pass is needed.
module arp_cache_oldest_replace (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_req_if.sink   req_i,
  arpc_rsp_if.source rsp_o
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Latched request
  logic              op_q;
  logic [IP_W-1:0]   ip_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;

  // Scan control
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;

  // Scan results
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [MAC_W-1:0]  hit_mac_q, hit_mac_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [TIME_W-1:0] best_time_q, best_time_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;

  // Entry store
  logic [CACHE_ENTRIES-1:0] vld_q, vld_d;
  logic [IP_W-1:0]          mem_ip   [CACHE_ENTRIES];
  logic [MAC_W-1:0]         mem_mac  [CACHE_ENTRIES];
  logic [TIME_W-1:0]        mem_time [CACHE_ENTRIES];
  logic [IP_W-1:0]          rd_ip_q;
  logic [MAC_W-1:0]         rd_mac_q;
  logic [TIME_W-1:0]        rd_time_q;

  // Response register
  logic              out_vld_q, out_vld_d;
  logic              out_found_q, out_found_d;
  logic [MAC_W-1:0]  out_mac_q, out_mac_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic             in_acc;
  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  logic             ev_match;
  logic             ev_older;
  logic             out_free;
  logic             fin_go;
  logic [IDX_W-1:0] tgt_idx;
  logic             wr_ip;
  logic             wr_mt;

  assign req_i.ready   = (state_q == S_IDLE);
  assign in_acc        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.found   = out_found_q;
  assign rsp_o.mac_out = out_mac_q;
  assign rsp_o.slot    = out_slot_q;

  // Scan datapath: one address compare and one timestamp compare per cycle
  assign issue    = (state_q == S_SCAN) && (cnt_q != CNT_W'(CACHE_ENTRIES));
  assign rd_addr  = cnt_q[IDX_W-1:0];
  assign ev_match = ev_vld_q && vld_q[ev_idx_q] && (rd_ip_q == ip_q);
  assign ev_older = (ev_idx_q == '0) || (rd_time_q < best_time_q);

  // Write-back target and strobes
  assign out_free = !out_vld_q || rsp_o.ready;
  assign fin_go   = (state_q == S_FINISH) && out_free;
  assign tgt_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_idx_q);
  assign wr_mt    = fin_go && (op_q == OP_ADD);
  assign wr_ip    = wr_mt && !hit_q;

  // Sequencer and next-state logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ev_vld_d    = issue;
    ev_idx_d    = rd_addr;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_mac_d   = hit_mac_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_time_d = best_time_q;
    best_idx_d  = best_idx_q;
    vld_d       = vld_q;
    out_vld_d   = out_vld_q;
    out_found_d = out_found_q;
    out_mac_d   = out_mac_q;
    out_slot_d  = out_slot_q;

    // Release a response once its transaction completes
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_FINISH;
        end
        // Evaluate the entry read in the previous cycle
        if (ev_vld_q) begin
          if (ev_match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = ev_idx_q;
            hit_mac_d = rd_mac_q;
          end
          if (!vld_q[ev_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = ev_idx_q;
          end
          if (ev_older) begin
            best_time_d = rd_time_q;
            best_idx_d  = ev_idx_q;
          end
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_d     = S_IDLE;
          out_vld_d   = 1'b1;
          out_found_d = hit_q;
          out_mac_d   = ((op_q == OP_LOOKUP) && hit_q) ? hit_mac_q : '0;
          out_slot_d  = (hit_q || (op_q == OP_ADD)) ? SLOT_W'(tgt_idx) : '0;
          if (wr_ip) begin
            vld_d[tgt_idx] = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ev_vld_q  <= ev_vld_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= req_i.opcode;
      ip_q  <= req_i.ip_addr;
      mac_q <= req_i.mac_in;
      now_q <= req_i.now_ms;
    end
    ev_idx_q    <= ev_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_mac_q   <= hit_mac_d;
    free_idx_q  <= free_idx_d;
    best_time_q <= best_time_d;
    best_idx_q  <= best_idx_d;
    out_found_q <= out_found_d;
    out_mac_q   <= out_mac_d;
    out_slot_q  <= out_slot_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_ip) begin
      mem_ip[tgt_idx] <= ip_q;
    end
    if (wr_mt) begin
      mem_mac[tgt_idx]  <= mac_q;
      mem_time[tgt_idx] <= now_q;
    end
    if (issue) begin
      rd_ip_q   <= mem_ip[rd_addr];
      rd_mac_q  <= mem_mac[rd_addr];
      rd_time_q <= mem_time[rd_addr];
    end
  end

  // Replacement by age only happens with every slot valid
  a_full_on_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && op_q == OP_ADD && !hit_q && !free_q) |-> (&vld_q))
    else $error("oldest-entry replacement with a free slot left");

  // An add leaves its target entry valid
  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ip |=> vld_q[$past(tgt_idx)])
    else $error("added entry not marked valid");

  // The sequencer reaches write-back only after a full scan
  a_full_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_FINISH) |-> ($past(cnt_q) == CNT_W'(CACHE_ENTRIES)))
    else $error("scan ended early");

  // A new response is loaded only from write-back
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_FINISH))
    else $error("response loaded outside write-back");

  // A non-zero MAC is only returned on a hit
  a_mac_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_mac_q != '0) |-> out_found_q)
    else $error("MAC returned without a hit");

endmodule
